// File: src/cth_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cth_pkg;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_START  = 2'd1,
    ACT_STOP   = 2'd2,
    ACT_RELOAD = 2'd3
  } action_t;

  localparam int unsigned REM_W = 26;
  localparam int unsigned TS_W  = 32;

  localparam logic [REM_W-1:0] MAX_PRESET_MS = 26'd39599000;

  localparam int unsigned MS_PER_SEC    = 1000;
  localparam int unsigned SEC_PER_HOUR  = 3600;
  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned MS_PER_CS     = 10;

  // Reciprocals m = ceil(2^k / d); k picked so that x * (m*d - 2^k) < 2^k
  // over the whole input range, which makes (x * m) >> k exact.
  localparam int unsigned REC_1000_K = 36;
  localparam longint unsigned REC_1000_M =
    ((64'd1 << REC_1000_K) + 64'(MS_PER_SEC) - 64'd1) / 64'(MS_PER_SEC);
  localparam int unsigned REC_3600_K = 28;
  localparam longint unsigned REC_3600_M =
    ((64'd1 << REC_3600_K) + 64'(SEC_PER_HOUR) - 64'd1) / 64'(SEC_PER_HOUR);
  localparam int unsigned REC_60_K = 18;
  localparam longint unsigned REC_60_M =
    ((64'd1 << REC_60_K) + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN);
  localparam int unsigned REC_10_K = 14;
  localparam longint unsigned REC_10_M =
    ((64'd1 << REC_10_K) + 64'(MS_PER_CS) - 64'd1) / 64'(MS_PER_CS);

  typedef struct packed {
    logic [REM_W-1:0] remaining;
    logic             running;
    logic             expired;
  } item_t;

endpackage

`default_nettype wire

// File: src/cth_state.sv
`timescale 1ns / 1ps
`default_nettype none

module cth_state
  import cth_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       action,
  input  wire logic [TS_W-1:0]  now_ms,
  input  wire logic             mode_active,
  input  wire logic [REM_W-1:0] preset_ms,
  output logic                  item_valid,
  input  wire logic             item_ready,
  output item_t                 item
);

  logic [REM_W-1:0] remaining, remaining_next;
  logic [TS_W-1:0]  last_tick, last_tick_next;
  logic             running, running_next;
  logic             expired_next;
  logic [TS_W-1:0]  base;
  logic [TS_W-1:0]  delta;
  logic             take;
  action_t          act;

  assign act      = action_t'(action);
  assign in_ready = !item_valid || item_ready;
  assign take     = in_valid && in_ready;

  assign base  = (last_tick == '0) ? now_ms : last_tick;
  assign delta = now_ms - base;

  always_comb begin
    remaining_next = remaining;
    last_tick_next = last_tick;
    running_next   = running;
    expired_next   = 1'b0;
    unique case (act)
      ACT_TICK: begin
        if (mode_active) begin
          if (running) begin
            last_tick_next = now_ms;
            if (delta >= TS_W'(remaining)) begin
              remaining_next = '0;
            end else begin
              remaining_next = remaining - delta[REM_W-1:0];
            end
            if (remaining_next == '0) begin
              running_next = 1'b0;
              expired_next = 1'b1;
            end
          end else begin
            last_tick_next = '0;
          end
        end
      end
      ACT_START:  running_next = 1'b1;
      ACT_STOP:   running_next = 1'b0;
      ACT_RELOAD: begin
        remaining_next = (preset_ms > MAX_PRESET_MS) ? MAX_PRESET_MS : preset_ms;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining  <= '0;
      last_tick  <= '0;
      running    <= 1'b0;
      item_valid <= 1'b0;
    end else begin
      if (take) begin
        remaining <= remaining_next;
        last_tick <= last_tick_next;
        running   <= running_next;
      end
      if (in_ready) begin
        item_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.remaining <= remaining_next;
      item.running   <= running_next;
      item.expired   <= expired_next;
    end
  end

endmodule

`default_nettype wire

// File: src/cth_split.sv
`timescale 1ns / 1ps
`default_nettype none

module cth_split
  import cth_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire item_t            item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [REM_W-1:0]      remaining_ms,
  output logic [3:0]            hours,
  output logic [5:0]            minutes,
  output logic [5:0]            seconds,
  output logic [6:0]            centiseconds,
  output logic                  is_running,
  output logic                  expired
);

  // Stage b: whole seconds
  logic             b_valid, b_ready;
  item_t            b_item;
  logic [15:0]      b_tsec;
  // Stage c: hours, millisecond part
  logic             c_valid, c_ready;
  item_t            c_item;
  logic [15:0]      c_tsec;
  logic [3:0]       c_hours;
  logic [9:0]       c_ms;
  // Stage d: seconds within the hour, centiseconds
  logic             d_valid, d_ready;
  item_t            d_item;
  logic [3:0]       d_hours;
  logic [11:0]      d_rsec;
  logic [6:0]       d_cs;
  // Stage e: minutes
  logic             e_valid, e_ready;
  item_t            e_item;
  logic [3:0]       e_hours;
  logic [11:0]      e_rsec;
  logic [6:0]       e_cs;
  logic [5:0]       e_min;
  logic             f_ready;

  logic [52:0]      p_sec;
  logic [32:0]      p_hour;
  logic [REM_W-1:0] ms_w;
  logic [15:0]      rsec_w;
  logic [20:0]      p_cs;
  logic [24:0]      p_min;
  logic [11:0]      sec_w;

  assign f_ready    = !out_valid || out_ready;
  assign e_ready    = !e_valid || f_ready;
  assign d_ready    = !d_valid || e_ready;
  assign c_ready    = !c_valid || d_ready;
  assign b_ready    = !b_valid || c_ready;
  assign item_ready = b_ready;

  assign p_sec  = 53'(item.remaining) * 53'(REC_1000_M);
  assign p_hour = 33'(b_tsec) * 33'(REC_3600_M);
  assign ms_w   = b_item.remaining - REM_W'(b_tsec) * REM_W'(MS_PER_SEC);
  assign rsec_w = c_tsec - 16'(c_hours) * 16'(SEC_PER_HOUR);
  assign p_cs   = 21'(c_ms) * 21'(REC_10_M);
  assign p_min  = 25'(d_rsec) * 25'(REC_60_M);
  assign sec_w  = e_rsec - 12'(e_min) * 12'(SEC_PER_MIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b_ready) b_valid <= item_valid;
      if (c_ready) c_valid <= b_valid;
      if (d_ready) d_valid <= c_valid;
      if (e_ready) e_valid <= d_valid;
      if (f_ready) out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && b_ready) begin
      b_item <= item;
      b_tsec <= p_sec[REC_1000_K+15:REC_1000_K];
    end
    if (b_valid && c_ready) begin
      c_item  <= b_item;
      c_tsec  <= b_tsec;
      c_hours <= p_hour[REC_3600_K+3:REC_3600_K];
      c_ms    <= ms_w[9:0];
    end
    if (c_valid && d_ready) begin
      d_item  <= c_item;
      d_hours <= c_hours;
      d_rsec  <= rsec_w[11:0];
      d_cs    <= p_cs[REC_10_K+6:REC_10_K];
    end
    if (d_valid && e_ready) begin
      e_item  <= d_item;
      e_hours <= d_hours;
      e_rsec  <= d_rsec;
      e_cs    <= d_cs;
      e_min   <= p_min[REC_60_K+5:REC_60_K];
    end
    if (e_valid && f_ready) begin
      remaining_ms <= e_item.remaining;
      is_running   <= e_item.running;
      expired      <= e_item.expired;
      hours        <= e_hours;
      minutes      <= e_min;
      seconds      <= sec_w[5:0];
      centiseconds <= e_cs;
    end
  end

endmodule

`default_nettype wire

// File: src/countdown_timer_hms.sv
// Throughput: one item per cycle while out_ready does not stall the output;
// the timer state updates in the accept cycle and the time split runs in a
// five-stage reciprocal-multiply pipeline. Each stage holds its own valid,
// so items keep entering while a result waits, as long as a stage is empty.
// Reset (synchronous, active high) clears remaining time, baseline, running
// flag, preset and all pipeline valids.
`timescale 1ns / 1ps
`default_nettype none

module countdown_timer_hms
  import cth_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // APB-style configuration port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input channel
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       action,
  input  wire logic [TS_W-1:0]  now_ms,
  input  wire logic             mode_active,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [REM_W-1:0]      remaining_ms,
  output logic [3:0]            hours,
  output logic [5:0]            minutes,
  output logic [5:0]            seconds,
  output logic [6:0]            centiseconds,
  output logic                  is_running,
  output logic                  expired
);

  logic [REM_W-1:0] preset_ms;
  logic             item_valid;
  logic             item_ready;
  item_t            item;

  // Register index is paddr[2]; only index zero (preset) exists.
  // Writes to the empty slot above it complete but change nothing.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(preset_ms) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      preset_ms <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      // drop the upper bits; reload saturates oversize presets
      preset_ms <= pwdata[REM_W-1:0];
    end
  end

  // Timer state: tick subtraction with clamp, start, stop, reload.
  // Each accepted transfer updates the state and lands in one register stage.
  cth_state u_state (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .now_ms      (now_ms),
    .mode_active (mode_active),
    .preset_ms   (preset_ms),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item)
  );

  // Time split: hours, minutes, seconds and centiseconds of the remaining
  // time, one constant division in each of stages b to e, ending in the output register.
  cth_split u_split (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .remaining_ms (remaining_ms),
    .hours        (hours),
    .minutes      (minutes),
    .seconds      (seconds),
    .centiseconds (centiseconds),
    .is_running   (is_running),
    .expired      (expired)
  );

endmodule

`default_nettype wire
